// ----- src/bsa_pkg.sv -----
// Package for the banker safe-allocation block: sizes, command and status codes.
// No dependencies.
`default_nettype none
package bsa_pkg;
    localparam int PROCESSES  = 8;
    localparam int RESOURCES  = 4;
    localparam int COUNT_BITS = 8;
    localparam int PW = 3;  // process field width
    localparam int RW = 2;  // resource field width
    localparam int WORK_BITS = COUNT_BITS + 3;
    localparam int ROW_BITS = RESOURCES * COUNT_BITS;
    localparam int PIDX = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RIDX = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    typedef enum logic [1:0] {
        CMD_AVAIL = 2'd0,
        CMD_MAX   = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_REQ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_GRANT  = 2'd0,
        ST_REFUSE = 2'd1,
        ST_UNSAFE = 2'd2
    } status_t;
endpackage
`default_nettype wire

// ----- src/banker_safe_allocation.sv -----
// Top level of the banker safe-allocation block: stream ports, sequencer and row memories.
// Depends on bsa_pkg and bsa_ram.
//
//  channel | dir | tdata fields (low bit up)                  | tuser | tlast
//  s_axis  | in  | command[1:0] process[4:2] resource[6:5]     | -     | last
//          |     | amount[14:7], pad to 16                    |       |
//  m_axis  | out | status[1:0] requester[4:2], pad to 8       | -     | -
//
// Availability beats and request beats without tlast are taken in the idle state;
// maximum and allocation beats read the row, modify it and write it back. After
// the last request element is taken, the process row is read and the request
// applied or refused; a checked request then runs the safety sweep, which reads
// one process row at a time from the need and allocation memories (S_SF_RD,
// S_SF_CHK); a rollback passes through S_RB. Reset clears availability and all
// rows of the tables through valid bits, per process row. A result waits in the
// output register and holds off every input beat until it is taken.
`default_nettype none
module banker_safe_allocation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // command, process, resource, amount
    input  wire logic        s_axis_tlast,  // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata   // status, requester
);
    import bsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LD_RD, S_LD_WR, S_RQ_RD, S_RQ_CHK, S_APPLY, S_SF_INIT,
        S_SF_RD, S_SF_CHK, S_SF_END, S_RB, S_OUT
    } state_t;

    state_t state_reg;

    // latched beat
    logic [1:0]            cmd_reg;
    logic [PW-1:0]         proc_reg;
    logic [RW-1:0]         res_reg;
    logic [COUNT_BITS-1:0] amt_reg;

    logic [COUNT_BITS-1:0] avail_reg [RESOURCES];
    logic [COUNT_BITS-1:0] rq_reg    [RESOURCES];
    logic [WORK_BITS-1:0]  work_reg  [RESOURCES];
    logic [PROCESSES-1:0]  fin_reg;
    logic [PROCESSES-1:0]  rowv_reg;   // row written since reset
    logic [PIDX-1:0]       scan_reg;   // process read during sweep
    logic                  found_reg;  // cleared at sweep start, never set
    logic                  safe_reg;
    logic [1:0]            status_reg;

    // row memories: one row per process, all resources packed
    logic                ram_we;
    logic [PIDX-1:0]     ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0] max_wd, alloc_wd, need_wd;
    logic [ROW_BITS-1:0] max_rd, alloc_rd, need_rd;
    logic [ROW_BITS-1:0] max_q, alloc_q, need_q;

    bsa_ram #(.WIDTH(ROW_BITS), .DEPTH(PROCESSES)) u_max (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(max_wd),
        .raddr(ram_raddr), .rdata(max_rd));
    bsa_ram #(.WIDTH(ROW_BITS), .DEPTH(PROCESSES)) u_alloc (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(alloc_wd),
        .raddr(ram_raddr), .rdata(alloc_rd));
    bsa_ram #(.WIDTH(ROW_BITS), .DEPTH(PROCESSES)) u_need (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(need_wd),
        .raddr(ram_raddr), .rdata(need_rd));

    // rows never written read as zero; valid bit sampled with the address
    logic rowv_q;
    assign max_q   = rowv_q ? max_rd   : '0;
    assign alloc_q = rowv_q ? alloc_rd : '0;
    assign need_q  = rowv_q ? need_rd  : '0;

    logic [PIDX-1:0] proc_idx;
    assign proc_idx = PIDX'(proc_reg);
    logic p_ok, r_ok;
    assign p_ok = ({1'b0, proc_reg} < (PW+1)'(PROCESSES));
    assign r_ok = ({1'b0, res_reg} < (RW+1)'(RESOURCES));

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {3'b000, proc_reg, status_reg};

    // row combinational views
    logic [ROW_BITS-1:0] ld_max, ld_alloc, ld_need;
    logic [ROW_BITS-1:0] ap_alloc, ap_need, rb_alloc, rb_need;
    logic refuse, fits;
    always_comb
    begin
        ld_max = max_q;
        ld_alloc = alloc_q;
        ld_need = need_q;
        ap_alloc = alloc_q;
        ap_need = need_q;
        rb_alloc = alloc_q;
        rb_need = need_q;
        refuse = !p_ok;
        fits = !fin_reg[scan_reg];
        for (int r = 0; r < RESOURCES; r++)
        begin
            logic [COUNT_BITS-1:0] m, a, n;
            m = max_q[r*COUNT_BITS +: COUNT_BITS];
            a = alloc_q[r*COUNT_BITS +: COUNT_BITS];
            n = need_q[r*COUNT_BITS +: COUNT_BITS];
            if (RIDX'(r) == RIDX'(res_reg))
            begin
                if (cmd_reg == CMD_MAX) m = amt_reg;
                else a = amt_reg;
            end
            ld_max[r*COUNT_BITS +: COUNT_BITS] = m;
            ld_alloc[r*COUNT_BITS +: COUNT_BITS] = a;
            ld_need[r*COUNT_BITS +: COUNT_BITS] = (m > a) ? m - a : '0;
            if (rq_reg[r] > n || rq_reg[r] > avail_reg[r]) refuse = 1'b1;
            ap_alloc[r*COUNT_BITS +: COUNT_BITS] =
                alloc_q[r*COUNT_BITS +: COUNT_BITS] + rq_reg[r];
            ap_need[r*COUNT_BITS +: COUNT_BITS] = n - rq_reg[r];
            rb_alloc[r*COUNT_BITS +: COUNT_BITS] =
                alloc_q[r*COUNT_BITS +: COUNT_BITS] - rq_reg[r];
            rb_need[r*COUNT_BITS +: COUNT_BITS] = n + rq_reg[r];
            if (WORK_BITS'(n) > work_reg[r]) fits = 1'b0;
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = proc_idx;
        ram_raddr = proc_idx;
        max_wd = max_q;
        alloc_wd = alloc_q;
        need_wd = need_q;
        unique case (state_reg)
            S_LD_WR:
            begin
                ram_we = 1'b1;
                max_wd = ld_max;
                alloc_wd = ld_alloc;
                need_wd = ld_need;
            end
            S_APPLY:
            begin
                ram_we = !refuse;
                alloc_wd = ap_alloc;
                need_wd = ap_need;
            end
            S_RB:
            begin
                ram_we = 1'b1;
                alloc_wd = rb_alloc;
                need_wd = rb_need;
            end
            S_SF_INIT, S_SF_RD, S_SF_CHK: ram_raddr = scan_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rowv_reg <= '0;
            rowv_q <= 1'b0;
            fin_reg <= '0;
            scan_reg <= '0;
            found_reg <= 1'b0;
            safe_reg <= 1'b0;
            status_reg <= ST_GRANT;
            cmd_reg <= '0;
            proc_reg <= '0;
            res_reg <= '0;
            amt_reg <= '0;
            for (int r = 0; r < RESOURCES; r++)
            begin
                avail_reg[r] <= '0;
                rq_reg[r] <= '0;
                work_reg[r] <= '0;
            end
        end
        else
        begin
            rowv_q <= rowv_reg[ram_raddr];
            if (ram_we) rowv_reg[ram_waddr] <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= s_axis_tdata[1:0];
                        proc_reg <= s_axis_tdata[4:2];
                        res_reg <= s_axis_tdata[6:5];
                        amt_reg <= COUNT_BITS'(s_axis_tdata[14:7]);
                        unique case (s_axis_tdata[1:0])
                            CMD_AVAIL:
                            begin
                                if ({1'b0, s_axis_tdata[6:5]} < (RW+1)'(RESOURCES))
                                    avail_reg[RIDX'(s_axis_tdata[6:5])] <=
                                        COUNT_BITS'(s_axis_tdata[14:7]);
                            end
                            CMD_REQ:
                            begin
                                if ({1'b0, s_axis_tdata[6:5]} < (RW+1)'(RESOURCES))
                                    rq_reg[RIDX'(s_axis_tdata[6:5])] <=
                                        COUNT_BITS'(s_axis_tdata[14:7]);
                                if (s_axis_tlast) state_reg <= S_RQ_RD;
                            end
                            default: state_reg <= S_LD_RD;
                        endcase
                    end
                end
                S_LD_RD: state_reg <= (p_ok && r_ok) ? S_LD_WR : S_IDLE;
                S_LD_WR: state_reg <= S_IDLE;
                S_RQ_RD: state_reg <= S_RQ_CHK;
                S_RQ_CHK: state_reg <= S_APPLY;
                S_APPLY:
                begin
                    if (refuse)
                    begin
                        status_reg <= ST_REFUSE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        for (int r = 0; r < RESOURCES; r++)
                            avail_reg[r] <= avail_reg[r] - rq_reg[r];
                        state_reg <= S_SF_INIT;
                    end
                end
                S_SF_INIT:
                begin
                    for (int r = 0; r < RESOURCES; r++)
                        work_reg[r] <= WORK_BITS'(avail_reg[r]);
                    fin_reg <= '0;
                    scan_reg <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SF_RD;
                end
                S_SF_RD: state_reg <= S_SF_CHK;   // read latency
                S_SF_CHK:
                begin
                    if (fits)
                    begin
                        // lowest fitting process of this round finishes
                        fin_reg[scan_reg] <= 1'b1;
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            logic [WORK_BITS:0] s;
                            s = {1'b0, work_reg[r]} +
                                (WORK_BITS+1)'(alloc_q[r*COUNT_BITS +: COUNT_BITS]);
                            work_reg[r] <= s[WORK_BITS] ? '1 : s[WORK_BITS-1:0];
                        end
                        scan_reg <= '0;
                        state_reg <= S_SF_RD;
                    end
                    else if (scan_reg == PIDX'(PROCESSES-1))
                        state_reg <= S_SF_END;
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        state_reg <= S_SF_RD;
                    end
                end
                S_SF_END:
                begin
                    if (&fin_reg)
                    begin
                        status_reg <= ST_GRANT;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        for (int r = 0; r < RESOURCES; r++)
                            avail_reg[r] <= avail_reg[r] + rq_reg[r];
                        state_reg <= S_RB;
                    end
                end
                S_RB:
                begin
                    status_reg <= ST_UNSAFE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        for (int r = 0; r < RESOURCES; r++) rq_reg[r] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/bsa_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/bsa_checker.sv -----
// Port-level checker for banker_safe_allocation, bound to the top level.
// Depends on bsa_pkg.
`default_nettype none
module bsa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);
    import bsa_pkg::*;

    // no input taken while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during result");
    // status is a defined code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
    // result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    // after a result is taken the block is ready again
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("not ready");
endmodule

bind banker_safe_allocation bsa_checker u_bsa_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire
